// ----- src/dht11_single_wire_reader_unit_macros.svh -----
// Assertion macros for the single-wire sensor reader.
// Included by the top level; no other dependencies.
`ifndef DHT11_SINGLE_WIRE_READER_UNIT_MACROS_SVH
`define DHT11_SINGLE_WIRE_READER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Condition must hold in the same cycle as the trigger.
`define DSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsr: same-cycle check failed");
// Condition must hold in the cycle after the trigger.
`define DSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsr: next-cycle check failed");
`else
`define DSR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/dsr_pkg.sv -----
// Shared types and constants for the single-wire sensor reader.
// No dependencies; imported by every module of the block.
package dsr_pkg;

    // Configuration port
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MEASURE_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW_TICKS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_TICKS    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_DELAY     = 2'd3;

    // Register widths and reset values
    localparam int INTERVAL_REG_W = 24;
    localparam int PHASE_TIMER_W  = 16;
    localparam int SHORT_REG_W    = 8;

    localparam logic [INTERVAL_REG_W-1:0] MEASURE_INTERVAL_RST = 24'd1500000;
    localparam logic [PHASE_TIMER_W-1:0]  START_LOW_TICKS_RST  = 16'd20000;
    localparam logic [SHORT_REG_W-1:0]    RELEASE_TICKS_RST    = 8'd7;
    localparam logic [SHORT_REG_W-1:0]    SAMPLE_DELAY_RST     = 8'd40;

    // Parameter defaults
    localparam int READ_BITS_DEF      = 32;
    localparam int INTERVAL_WIDTH_DEF = 24;

    // Width used to compare interval timer with its limit
    localparam int INTERVAL_CMP_W = 32;

    // Held reading
    localparam int HELD_W = 32;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_LOW,
        PH_RELEASE,
        PH_RESP_H1,
        PH_RESP_L,
        PH_RESP_H2,
        PH_BIT_RISE,
        PH_BIT_DELAY,
        PH_BIT_FALL
    } phase_t;

    typedef struct packed {
        logic [INTERVAL_REG_W-1:0] measure_interval;
        logic [PHASE_TIMER_W-1:0]  start_low_ticks;
        logic [SHORT_REG_W-1:0]    release_ticks;
        logic [SHORT_REG_W-1:0]    sample_delay;
    } cfg_t;

    typedef struct packed {
        logic              drive_low;
        logic              reading_valid;
        logic [HELD_W-1:0] held;
    } result_t;

endpackage

// ----- src/dsr_cfg_regs.sv -----
// Configuration register file of the sensor reader.
// Depends on dsr_pkg for register indexes, widths and reset values.
module dsr_cfg_regs
    import dsr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MEASURE_INTERVAL: cfg_next.measure_interval = cfg_data[INTERVAL_REG_W-1:0];
                CFG_START_LOW_TICKS:  cfg_next.start_low_ticks  = cfg_data[PHASE_TIMER_W-1:0];
                CFG_RELEASE_TICKS:    cfg_next.release_ticks    = cfg_data[SHORT_REG_W-1:0];
                CFG_SAMPLE_DELAY:     cfg_next.sample_delay     = cfg_data[SHORT_REG_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.measure_interval <= MEASURE_INTERVAL_RST;
            cfg_reg.start_low_ticks  <= START_LOW_TICKS_RST;
            cfg_reg.release_ticks    <= RELEASE_TICKS_RST;
            cfg_reg.sample_delay     <= SAMPLE_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/dsr_core.sv -----
// Sequencer of the sensor reader: start pulse, response tracking, bit capture.
// Depends on dsr_pkg for the phase type, configuration and result structs.
module dsr_core
    import dsr_pkg::*;
#(
    parameter int READ_BITS      = READ_BITS_DEF,
    parameter int INTERVAL_WIDTH = INTERVAL_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    line_level,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int BIT_COUNT_W = $clog2(READ_BITS + 1);
    localparam logic [BIT_COUNT_W-1:0] READ_BITS_CNT = BIT_COUNT_W'(READ_BITS);

    phase_t                    phase_reg,  phase_next;
    logic [INTERVAL_WIDTH-1:0] itimer_reg, itimer_next;
    logic [PHASE_TIMER_W-1:0]  ptimer_reg, ptimer_next;
    logic [BIT_COUNT_W-1:0]    bcount_reg, bcount_next;
    logic [READ_BITS-1:0]      shift_reg,  shift_next;
    logic [HELD_W-1:0]         held_reg,   held_next;
    logic                      done;
    logic                      interval_due;

    assign interval_due = (INTERVAL_CMP_W'(itimer_reg) >= INTERVAL_CMP_W'(cfg.measure_interval));

    // Next state for one tick; phases may fall through within the tick
    always_comb
    begin
        phase_next  = phase_reg;
        itimer_next = itimer_reg;
        ptimer_next = ptimer_reg;
        bcount_next = bcount_reg;
        shift_next  = shift_reg;
        held_next   = held_reg;
        done        = 1'b0;
        if (step)
        begin
            if (phase_reg == PH_IDLE && interval_due)
            begin
                itimer_next = '0;
                phase_next  = PH_START_LOW;
                ptimer_next = PHASE_TIMER_W'(1);
            end
            else
            begin
                // interval timer saturates
                if (itimer_reg != '1)
                begin
                    itimer_next = itimer_reg + INTERVAL_WIDTH'(1);
                end

                if (phase_next == PH_START_LOW)
                begin
                    if (ptimer_next >= cfg.start_low_ticks)
                    begin
                        phase_next  = PH_RELEASE;
                        ptimer_next = '0;
                    end
                    else
                    begin
                        ptimer_next = ptimer_next + PHASE_TIMER_W'(1);
                    end
                end

                if (phase_next == PH_RELEASE)
                begin
                    if (ptimer_next >= PHASE_TIMER_W'(cfg.release_ticks))
                    begin
                        phase_next = PH_RESP_H1;
                    end
                    else
                    begin
                        ptimer_next = ptimer_next + PHASE_TIMER_W'(1);
                    end
                end

                case (phase_next)
                    PH_RESP_H1:
                    begin
                        if (!line_level)
                        begin
                            phase_next = PH_RESP_L;
                        end
                    end
                    PH_RESP_L:
                    begin
                        if (line_level)
                        begin
                            phase_next = PH_RESP_H2;
                        end
                    end
                    PH_RESP_H2:
                    begin
                        if (!line_level)
                        begin
                            phase_next  = PH_BIT_RISE;
                            bcount_next = '0;
                            shift_next  = '0;
                        end
                    end
                    PH_BIT_RISE:
                    begin
                        if (line_level)
                        begin
                            phase_next  = PH_BIT_DELAY;
                            ptimer_next = '0;
                        end
                    end
                    PH_BIT_DELAY:
                    begin
                        ptimer_next = ptimer_reg + PHASE_TIMER_W'(1);
                        if (ptimer_next >= PHASE_TIMER_W'(cfg.sample_delay))
                        begin
                            shift_next  = {shift_reg[READ_BITS-2:0], line_level};
                            bcount_next = bcount_reg + BIT_COUNT_W'(1);
                            phase_next  = PH_BIT_FALL;
                        end
                    end
                    PH_BIT_FALL:
                    begin
                        if (!line_level)
                        begin
                            if (bcount_reg >= READ_BITS_CNT)
                            begin
                                // all READ_BITS bits received; the first 32 are held, any later checksum bits dropped
                                held_next  = shift_reg[READ_BITS-1 -: HELD_W];
                                done       = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_BIT_RISE;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_next;
                    end
                endcase
            end
        end
    end

    // Result of this tick
    always_comb
    begin
        result.drive_low     = (phase_next == PH_START_LOW);
        result.reading_valid = done;
        result.held          = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            itimer_reg <= '0;
            ptimer_reg <= '0;
            bcount_reg <= '0;
            shift_reg  <= '0;
            held_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            itimer_reg <= itimer_next;
            ptimer_reg <= ptimer_next;
            bcount_reg <= bcount_next;
            shift_reg  <= shift_next;
            held_reg   <= held_next;
        end
    end

endmodule

// ----- src/dsr_out_buf.sv -----
// Output register with skid stage for the sensor reader's result channel.
// Depends on dsr_pkg for the result struct.
module dsr_out_buf
    import dsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg,   out_data_next;
    result_t skid_data_reg,  skid_data_next;
    logic    out_free;

    // output slot can take a beat when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- src/dht11_single_wire_reader_unit.sv -----
// Top level of the single-wire humidity/temperature sensor reader.
// Depends on dsr_pkg, dsr_cfg_regs, dsr_core, dsr_out_buf and the macros header.
//
// Usage:
//   Input channel (in_valid / in_stall / line_level): one beat per microsecond
//   tick carrying the sampled sensor line level.
//   Output channel (out_valid / out_stall / drive_low, reading_valid and the
//   four reading bytes): exactly one result beat per input beat, in order.
//   drive_low pulls the line during the start pulse; reading_valid pulses on
//   the beat that completes a reading; the bytes hold the last reading.
//   Configuration: cfg_we / cfg_index / cfg_data write one register per
//   cycle (0 measure interval, 1 start low ticks, 2 release ticks,
//   3 sample delay); write only while the block is idle.
//   Each result beat is registered in the output register; one beat is taken
//   every cycle while in_stall is low, the sequencer handling one tick per cycle.
//   A stalled result waits in the output register; one more beat is then
//   held in the skid stage, after which in_stall rises until the output drains.
//   Reset clears the sequencer, timers and reading, and loads the default
//   register values; no clearing pass is needed.
`include "dht11_single_wire_reader_unit_macros.svh"

module dht11_single_wire_reader_unit
    import dsr_pkg::*;
#(
    parameter int READ_BITS      = READ_BITS_DEF,
    parameter int INTERVAL_WIDTH = INTERVAL_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   line_level,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   drive_low,
    output logic                   reading_valid,
    output logic [7:0]             humidity_int,
    output logic [7:0]             humidity_frac,
    output logic [7:0]             temp_int,
    output logic [7:0]             temp_frac
);

    cfg_t    cfg;
    result_t tick_result;
    result_t out_data;
    logic    in_fire;

    assign in_fire = in_valid && !in_stall;

    dsr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dsr_core #(
        .READ_BITS      (READ_BITS),
        .INTERVAL_WIDTH (INTERVAL_WIDTH)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_fire),
        .line_level (line_level),
        .cfg        (cfg),
        .result     (tick_result)
    );

    dsr_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (tick_result),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Result fields
    assign drive_low     = out_data.drive_low;
    assign reading_valid = out_data.reading_valid;
    assign humidity_int  = out_data.held[31:24];
    assign humidity_frac = out_data.held[23:16];
    assign temp_int      = out_data.held[15:8];
    assign temp_frac     = out_data.held[7:0];

    // Skid stage only fills behind a full output register
    `DSR_ASSERT_SAME(a_skid_behind_out, clk, rst_n, in_stall, out_valid)
    // After an accepted beat the output is always valid in the next cycle
    `DSR_ASSERT_NEXT(a_accept_shows, clk, rst_n, in_valid && !in_stall, out_valid)
    // A completed reading ends the sequence, never inside the start pulse
    `DSR_ASSERT_SAME(a_valid_not_driving, clk, rst_n, out_valid && reading_valid, !drive_low)

endmodule

// ----- tb/dht11_single_wire_reader_unit_tb.sv -----
// Self-checking testbench for the single-wire sensor reader top level.
// Depends on dsr_pkg and the RTL; a behavioural sensor drives the line level.
module dht11_single_wire_reader_unit_tb;
    import dsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BURST_MAX   = 6;
    localparam int REPORT_CAP  = 40;
    localparam int RANDOM_TICKS = 100;
    localparam int RANDOM_READINGS = 1;

    // Clock, reset and block ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic line_level = 1'b1;
    logic out_valid;
    logic out_stall = 1'b0;
    logic drive_low;
    logic reading_valid;
    logic [7:0] humidity_int;
    logic [7:0] humidity_frac;
    logic [7:0] temp_int;
    logic [7:0] temp_frac;

    // Reader state as the testbench tracks it
    cfg_t        rd_cfg;
    phase_t      rd_phase;
    logic [23:0] rd_interval;
    logic [15:0] rd_ptimer;
    logic [5:0]  rd_bits;
    logic [31:0] rd_shift;
    logic [31:0] rd_held;

    // Result beats still owed by the block, oldest first
    result_t tick_result_q[$];

    // Sensor behaviour
    phase_t      sensor_last_phase = PH_IDLE;
    int          hold_left = 0;
    int          max_hold = 2;
    int          noise_pct = 0;
    logic [31:0] plan_word = '0;
    logic        fixed_plan_on = 1'b0;
    logic [31:0] fixed_plan = '0;

    // Run bookkeeping
    bit calm = 1'b0;
    int stall_left = 0;
    int mismatches = 0;
    int ticks_sent = 0;
    int readings_done = 0;
    int settings_used = 0;

    dht11_single_wire_reader_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .line_level    (line_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive_low     (drive_low),
        .reading_valid (reading_valid),
        .humidity_int  (humidity_int),
        .humidity_frac (humidity_frac),
        .temp_int      (temp_int),
        .temp_frac     (temp_frac)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reader state after reset
    function automatic void clear_reader();
        rd_cfg = '{MEASURE_INTERVAL_RST, START_LOW_TICKS_RST, RELEASE_TICKS_RST,
                   SAMPLE_DELAY_RST};
        rd_phase = PH_IDLE;
        rd_interval = '0;
        rd_ptimer = '0;
        rd_bits = '0;
        rd_shift = '0;
        rd_held = '0;
    endfunction

    // Advance the reader by one tick and queue the result beat it owes
    function automatic void step_reader(input logic lvl);
        result_t r;
        r.reading_valid = 1'b0;
        if (rd_phase == PH_IDLE && rd_interval >= rd_cfg.measure_interval)
        begin
            rd_interval = '0;
            rd_phase = PH_START_LOW;
            rd_ptimer = 16'd1;
        end
        else
        begin
            if (rd_interval != '1)
                rd_interval++;
            if (rd_phase == PH_START_LOW)
            begin
                if (rd_ptimer >= rd_cfg.start_low_ticks)
                begin
                    rd_phase = PH_RELEASE;
                    rd_ptimer = '0;
                end
                else
                    rd_ptimer++;
            end
            // release may end on the same tick the low pulse ends
            if (rd_phase == PH_RELEASE)
            begin
                if (rd_ptimer >= rd_cfg.release_ticks)
                    rd_phase = PH_RESP_H1;
                else
                    rd_ptimer++;
            end
            case (rd_phase)
                PH_RESP_H1:
                    if (!lvl)
                        rd_phase = PH_RESP_L;
                PH_RESP_L:
                    if (lvl)
                        rd_phase = PH_RESP_H2;
                PH_RESP_H2:
                    if (!lvl)
                    begin
                        rd_phase = PH_BIT_RISE;
                        rd_bits = '0;
                        rd_shift = '0;
                    end
                PH_BIT_RISE:
                    if (lvl)
                    begin
                        rd_phase = PH_BIT_DELAY;
                        rd_ptimer = '0;
                    end
                PH_BIT_DELAY:
                begin
                    rd_ptimer++;
                    if (rd_ptimer >= rd_cfg.sample_delay)
                    begin
                        rd_shift = {rd_shift[30:0], lvl};
                        rd_bits++;
                        rd_phase = PH_BIT_FALL;
                    end
                end
                PH_BIT_FALL:
                    if (!lvl)
                    begin
                        if (rd_bits >= 6'd32)
                        begin
                            rd_held = rd_shift;
                            r.reading_valid = 1'b1;
                            rd_phase = PH_IDLE;
                        end
                        else
                            rd_phase = PH_BIT_RISE;
                    end
                default: ;
            endcase
        end
        r.drive_low = (rd_phase == PH_START_LOW);
        r.held = rd_held;
        tick_result_q.push_back(r);
        ticks_sent++;
        if (r.reading_valid)
            readings_done++;
    endfunction

    // Line level a well-behaved sensor shows on the next tick
    function automatic logic sensor_level();
        logic lvl;
        logic bit_val;
        logic sample_now;
        if (rd_phase != sensor_last_phase)
        begin
            hold_left = $urandom_range(0, max_hold);
            if (rd_phase == PH_START_LOW)
                plan_word = fixed_plan_on ? fixed_plan : $urandom;
            sensor_last_phase = rd_phase;
        end
        bit_val = plan_word[31 - int'(rd_bits[4:0])];
        sample_now = (rd_ptimer + 16'd1) >= {8'd0, rd_cfg.sample_delay};
        case (rd_phase)
            PH_IDLE, PH_RELEASE:
                lvl = 1'b1;
            PH_START_LOW:
                lvl = 1'b0;
            PH_RESP_H1, PH_RESP_H2, PH_BIT_FALL:
                lvl = (hold_left != 0);
            PH_RESP_L, PH_BIT_RISE:
                lvl = (hold_left == 0);
            PH_BIT_DELAY:
                lvl = (sample_now || bit_val) ? bit_val : 1'($urandom_range(0, 1));
            default:
                lvl = 1'b1;
        endcase
        if (hold_left != 0)
            hold_left--;
        if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
            lvl = 1'($urandom_range(0, 1));
        return lvl;
    endfunction

    // Send one tick beat; valid stays high afterwards so back-to-back beats need no dip
    task automatic send_tick(input logic lvl);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
        end
        in_valid <= 1'b1;
        line_level <= lvl;
        do
            @(posedge clk);
        while (in_stall);
        step_reader(lvl);
    endtask

    // Hold off the sender until every owed result beat has come back
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (tick_result_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Write all four registers while no beat is in flight
    task automatic program_regs(input logic [23:0] interval, input logic [15:0] low_ticks,
                                input logic [7:0] rel_ticks, input logic [7:0] delay);
        wait_until_drained();
        cfg_we <= 1'b1;
        put_reg(CFG_MEASURE_INTERVAL, interval);
        put_reg(CFG_START_LOW_TICKS, CFG_DATA_W'(low_ticks));
        put_reg(CFG_RELEASE_TICKS, CFG_DATA_W'(rel_ticks));
        put_reg(CFG_SAMPLE_DELAY, CFG_DATA_W'(delay));
        cfg_we <= 1'b0;
        rd_cfg = '{interval, low_ticks, rel_ticks, delay};
        settings_used++;
    endtask

    task automatic run_readings(input int n);
        int target;
        target = readings_done + n;
        while (readings_done < target)
            send_tick(sensor_level());
    endtask

    // Output side: random stall bursts, none once the run calms down
    always @(posedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, BURST_MAX);
        end
    end

    task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            if (mismatches < REPORT_CAP)
                $error("%s: expected %0h, got %0h", fname, want, got);
            mismatches++;
        end
    endtask

    // Compare each result beat with the oldest owed one
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tick_result_q.size() == 0)
            begin
                if (mismatches < REPORT_CAP)
                    $error("result beat arrived with nothing owed");
                mismatches++;
            end
            else
            begin
                want = tick_result_q.pop_front();
                check_field("drive_low", 8'(want.drive_low), 8'(drive_low));
                check_field("reading_valid", 8'(want.reading_valid), 8'(reading_valid));
                check_field("humidity_int", want.held[31:24], humidity_int);
                check_field("humidity_frac", want.held[23:16], humidity_frac);
                check_field("temp_int", want.held[15:8], temp_int);
                check_field("temp_frac", want.held[7:0], temp_frac);
            end
        end
    end

    // Default registers: the interval is far off, so nothing but zeros
    task automatic test_reset_defaults();
        repeat (20)
            send_tick(1'($urandom_range(0, 1)));
    endtask

    // Every register at its top value; no trigger within reach
    task automatic test_interval_limits();
        program_regs(24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        repeat (30)
            send_tick(1'($urandom_range(0, 1)));
    endtask

    // Zero start time, release and sample delay, sensor answering at once, then with random holds on the third reading
    task automatic test_zero_timing();
        max_hold = 0;
        noise_pct = 0;
        fixed_plan_on = 1'b1;
        program_regs(24'd0, 16'd0, 8'd0, 8'd0);
        fixed_plan = 32'hFFFF_FFFF;
        run_readings(1);
        fixed_plan = 32'h0000_0000;
        run_readings(1);
        fixed_plan = 32'hA55A_3CC3;
        max_hold = 1;
        run_readings(1);
        fixed_plan_on = 1'b0;
    endtask

    // Top release time, top sample delay on the first bit, then quick bits
    task automatic test_long_timing();
        max_hold = 2;
        program_regs(24'd0, 16'd20, 8'hFF, 8'hFF);
        while (rd_phase != PH_BIT_FALL)
            send_tick(sensor_level());
        max_hold = 0;
        program_regs(24'd0, 16'd20, 8'hFF, 8'd0);
        run_readings(1);
    endtask

    // Line stuck high after release: the block waits for the response
    task automatic test_stuck_line();
        program_regs(24'd0, 16'd4, 8'd2, 8'd3);
        repeat (40)
            send_tick(1'b1);
    endtask

    // Reading picked up after the stuck line; sample delay changed part way through
    task automatic test_write_mid_reading();
        max_hold = 2;
        program_regs(24'd0, 16'd6, 8'd1, 8'd2);
        while (!(rd_phase == PH_BIT_RISE && rd_bits == 6'd12))
            send_tick(sensor_level());
        program_regs(24'd50, 16'd6, 8'd1, 8'd6);
        run_readings(1);
    endtask

    // Random settings and sensor timing, some noisy or cut-off readings
    task automatic test_random_readings();
        int first_tick;
        int first_reading;
        first_tick = ticks_sent;
        first_reading = readings_done;
        while (ticks_sent - first_tick < RANDOM_TICKS
               || readings_done - first_reading < RANDOM_READINGS)
        begin
            max_hold = $urandom_range(0, 2);
            noise_pct = ($urandom_range(0, 7) == 0) ? 25 : 0;
            repeat ($urandom_range(0, 40))
                send_tick(sensor_level());
            if ($urandom_range(0, 2) == 0)
                program_regs(($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 400))
                                                         : 24'($urandom_range(0, 100)),
                             ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 100))
                                                         : 16'($urandom_range(0, 20)),
                             ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 40))
                                                         : 8'($urandom_range(0, 8)),
                             ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 20))
                                                         : 8'($urandom_range(0, 4)));
            run_readings(1);
        end
        // closing stretch with neither side idling
        calm = 1'b1;
        noise_pct = 0;
        run_readings(1);
    endtask

    initial
    begin
        clear_reader();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_interval_limits();
        test_zero_timing();
        test_long_timing();
        test_stuck_line();
        test_write_mid_reading();
        test_random_readings();

        wait_until_drained();
        repeat (4) @(posedge clk);
        $display("Covered %0d sensor ticks and %0d completed readings over %0d register settings,",
                 ticks_sent, readings_done, settings_used);
        $display("including zero and top timings, a stuck line and a write mid-reading.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- dht11_single_wire_reader_unit.f -----
+incdir+src
src/dsr_pkg.sv
src/dsr_cfg_regs.sv
src/dsr_core.sv
src/dsr_out_buf.sv
src/dht11_single_wire_reader_unit.sv
tb/dht11_single_wire_reader_unit_tb.sv
